### hw/rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and codes for the indexed min-heap queue: request and
// response items, command and status codes, and the controller states.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int unsigned HEAP_SLOTS_DEF   = 256;
  localparam int unsigned VERTEX_COUNT_DEF = 256;
  localparam int unsigned KEY_BITS_DEF     = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [7:0]  vertex;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] min_key;
    logic [7:0]  min_vertex;
    logic [7:0]  slot;
    logic [7:0]  count;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_UP_READ,
    ST_UP_CMP,
    ST_DEL_ROOT,
    ST_DEL_LAST,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_PLACE,
    ST_RESULT
  } state_t;

endpackage

### hw/rtl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-port-write, single-port-read memory with a registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/imhq_engine.sv
// ----------------------------------------------------------------------------
// imhq_engine
// Command sequencer of the heap queue. It clears the position map after
// reset, then runs sift-up, sift-down and queries against the heap memory
// and the position map, and hands one result per item to the output stage.
// ----------------------------------------------------------------------------
module imhq_engine #(
  parameter int unsigned HEAP_SLOTS   = imhq_pkg::HEAP_SLOTS_DEF,
  parameter int unsigned VERTEX_COUNT = imhq_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned KEY_BITS     = imhq_pkg::KEY_BITS_DEF,
  localparam int unsigned SW = $clog2(HEAP_SLOTS),
  localparam int unsigned VW = $clog2(VERTEX_COUNT),
  localparam int unsigned EW = KEY_BITS + VW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  imhq_pkg::req_t       req,
  output imhq_pkg::res_t       res,
  input  logic                 res_ready,
  output logic                 heap_we,
  output logic [SW-1:0]        heap_waddr,
  output logic [EW-1:0]        heap_wdata,
  output logic [SW-1:0]        heap_raddr,
  input  logic [EW-1:0]        heap_rdata,
  output logic                 pos_we,
  output logic [VW-1:0]        pos_waddr,
  output logic [SW-1:0]        pos_wdata,
  output logic [VW-1:0]        pos_raddr,
  input  logic [SW-1:0]        pos_rdata
);

  import imhq_pkg::*;

  localparam logic [SW-1:0] MAX_COUNT = SW'(HEAP_SLOTS - 1);
  localparam logic [SW-1:0] ROOT      = SW'(1);
  localparam logic [VW-1:0] LAST_VTX  = VW'(VERTEX_COUNT - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VW-1:0]       vtx;
  } entry_t;

  function automatic logic [VW-1:0] fold_vertex(input logic [7:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (v == 8'(i)) begin
        r = VW'(i % VERTEX_COUNT);
      end
    end
    return r;
  endfunction

  state_t              state, state_next;
  logic [VW-1:0]       clr_idx, clr_idx_next;
  logic [SW-1:0]       count, count_next;
  logic [SW-1:0]       idx, idx_next;
  logic [KEY_BITS-1:0] hole_key, hole_key_next;
  logic [VW-1:0]       hole_vtx, hole_vtx_next;
  entry_t              child, child_next;
  logic                is_insert, is_insert_next;
  logic [1:0]          status, status_next;
  logic [KEY_BITS-1:0] min_key, min_key_next;
  logic [VW-1:0]       min_vtx, min_vtx_next;
  logic [SW-1:0]       slot, slot_next;

  entry_t        rd_entry;
  entry_t        cand;
  logic [SW-1:0] cand_idx;
  logic [SW:0]   cand_left;
  logic [SW:0]   left_wide;
  logic [SW-1:0] left_idx;
  logic [SW-1:0] parent_idx;
  logic          has_right;
  logic [VW-1:0] req_vtx;
  logic          accept;
  logic          dn_eval;

  assign rd_entry   = entry_t'(heap_rdata);
  assign left_wide  = {idx, 1'b0};
  assign left_idx   = left_wide[SW-1:0];
  assign parent_idx = idx >> 1;
  assign has_right  = left_wide < {1'b0, count};
  assign req_vtx    = fold_vertex(req.vertex);
  assign req_stall  = (state != ST_IDLE);
  assign accept     = req_valid && !req_stall;

  always_comb begin
    if (state == ST_DN_RIGHT && child.key > rd_entry.key) begin
      cand     = rd_entry;
      cand_idx = left_idx + ROOT;
    end else if (state == ST_DN_RIGHT) begin
      cand     = child;
      cand_idx = left_idx;
    end else begin
      cand     = rd_entry;
      cand_idx = left_idx;
    end
    cand_left = {cand_idx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    hole_key  <= hole_key_next;
    hole_vtx  <= hole_vtx_next;
    child     <= child_next;
    is_insert <= is_insert_next;
    status    <= status_next;
    min_key   <= min_key_next;
    min_vtx   <= min_vtx_next;
    slot      <= slot_next;
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    count_next     = count;
    idx_next       = idx;
    hole_key_next  = hole_key;
    hole_vtx_next  = hole_vtx;
    child_next     = child;
    is_insert_next = is_insert;
    status_next    = status;
    min_key_next   = min_key;
    min_vtx_next   = min_vtx;
    slot_next      = slot;
    dn_eval        = 1'b0;

    heap_we    = 1'b0;
    heap_waddr = idx;
    heap_wdata = EW'(cand);
    heap_raddr = idx;
    pos_we     = 1'b0;
    pos_waddr  = cand.vtx;
    pos_wdata  = idx;
    pos_raddr  = req_vtx;

    res.valid           = 1'b0;
    res.data.status     = status;
    res.data.min_key    = 16'(min_key);
    res.data.min_vertex = 8'(min_vtx);
    res.data.slot       = 8'(slot);
    res.data.count      = 8'(count);

    unique case (state)
      ST_CLEAR: begin
        pos_we       = 1'b1;
        pos_waddr    = clr_idx;
        pos_wdata    = '0;
        clr_idx_next = clr_idx + VW'(1);
        if (clr_idx == LAST_VTX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          hole_key_next  = KEY_BITS'(req.key);
          hole_vtx_next  = req_vtx;
          is_insert_next = (req.cmd == CMD_INSERT);
          status_next    = STATUS_OK;
          min_key_next   = '0;
          min_vtx_next   = '0;
          slot_next      = '0;
          unique case (req.cmd)
            CMD_INSERT: begin
              if (count == MAX_COUNT) begin
                status_next = STATUS_FULL;
                state_next  = ST_RESULT;
              end else begin
                count_next = count + ROOT;
                idx_next   = count + ROOT;
                state_next = (count == '0) ? ST_PLACE : ST_UP_READ;
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
                state_next  = ST_RESULT;
              end else begin
                heap_raddr = ROOT;
                state_next = ST_DEL_ROOT;
              end
            end
            CMD_QUERY: begin
              state_next = ST_QUERY;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_QUERY: begin
        slot_next  = pos_rdata;
        state_next = ST_RESULT;
      end
      ST_UP_READ: begin
        heap_raddr = parent_idx;
        state_next = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (rd_entry.key > hole_key) begin
          heap_we    = 1'b1;
          heap_wdata = EW'(rd_entry);
          pos_we     = 1'b1;
          pos_waddr  = rd_entry.vtx;
          idx_next   = parent_idx;
          if (parent_idx == ROOT) begin
            state_next = ST_PLACE;
          end else begin
            heap_raddr = parent_idx >> 1;
          end
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_DEL_ROOT: begin
        min_key_next = rd_entry.key;
        min_vtx_next = rd_entry.vtx;
        heap_raddr   = count;
        state_next   = ST_DEL_LAST;
      end
      ST_DEL_LAST: begin
        hole_key_next = rd_entry.key;
        hole_vtx_next = rd_entry.vtx;
        pos_we        = 1'b1;
        pos_waddr     = min_vtx;
        pos_wdata     = '0;
        count_next    = count - ROOT;
        idx_next      = ROOT;
        if (count == ROOT) begin
          state_next = ST_RESULT;
        end else if (count == SW'(2)) begin
          state_next = ST_PLACE;
        end else begin
          heap_raddr = SW'(2);
          state_next = ST_DN_LEFT;
        end
      end
      ST_DN_LEFT: begin
        child_next = rd_entry;
        if (has_right) begin
          heap_raddr = left_idx + ROOT;
          state_next = ST_DN_RIGHT;
        end else begin
          dn_eval = 1'b1;
        end
      end
      ST_DN_RIGHT: begin
        dn_eval = 1'b1;
      end
      ST_PLACE: begin
        heap_we    = 1'b1;
        heap_wdata = {hole_key, hole_vtx};
        pos_we     = 1'b1;
        pos_waddr  = hole_vtx;
        if (is_insert) begin
          slot_next = idx;
        end
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase

    if (dn_eval) begin
      if (hole_key > cand.key) begin
        heap_we  = 1'b1;
        pos_we   = 1'b1;
        idx_next = cand_idx;
        if (cand_left <= {1'b0, count}) begin
          heap_raddr = cand_left[SW-1:0];
          state_next = ST_DN_LEFT;
        end else begin
          state_next = ST_PLACE;
        end
      end else begin
        state_next = ST_PLACE;
      end
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("entry count above heap capacity");

  a_heap_waddr: assert property (@(posedge clk) disable iff (rst)
    heap_we |-> (heap_waddr != '0) && (heap_waddr <= count))
    else $error("heap write outside occupied slots");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.status == STATUS_EMPTY) |-> (count == '0))
    else $error("empty status with entries present");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> res.valid && $stable(res.data))
    else $error("result changed while output stage was full");

endmodule

### hw/rtl/imhq_out.sv
// ----------------------------------------------------------------------------
// imhq_out
// Output register stage. It holds one finished result until the receiver
// takes it, so the engine can accept and work on the next item meanwhile.
// ----------------------------------------------------------------------------
module imhq_out (
  input  logic           clk,
  input  logic           rst,
  input  imhq_pkg::res_t res,
  output logic           res_ready,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output imhq_pkg::rsp_t rsp
);

  import imhq_pkg::*;

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      rsp <= res.data;
    end
  end

endmodule

### hw/rtl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Binary min-heap of (key, vertex) pairs in slots 1 onward, with a position
// map from vertex to slot. Supports insert, delete-minimum and position query.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  cmd, key, vertex
//   rsp      out  rsp_valid/rsp_stall  status, min_key, min_vertex, slot, count
//
// One item is worked on at a time. Inserts and deletes walk the heap level
// by level; the single read port of the heap memory sets the per-level cost.
// After reset the position map is cleared entry by entry, during which
// req_stall is high. A stalled result waits in the output register
// while the next item is accepted and processed.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
  parameter int unsigned HEAP_SLOTS   = imhq_pkg::HEAP_SLOTS_DEF,
  parameter int unsigned VERTEX_COUNT = imhq_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned KEY_BITS     = imhq_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  imhq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output imhq_pkg::rsp_t rsp
);

  import imhq_pkg::*;

  localparam int unsigned SW = $clog2(HEAP_SLOTS);
  localparam int unsigned VW = $clog2(VERTEX_COUNT);
  localparam int unsigned EW = KEY_BITS + VW;

  res_t          res;
  logic          res_ready;
  logic          heap_we;
  logic [SW-1:0] heap_waddr;
  logic [EW-1:0] heap_wdata;
  logic [SW-1:0] heap_raddr;
  logic [EW-1:0] heap_rdata;
  logic          pos_we;
  logic [VW-1:0] pos_waddr;
  logic [SW-1:0] pos_wdata;
  logic [VW-1:0] pos_raddr;
  logic [SW-1:0] pos_rdata;

  imhq_engine #(
    .HEAP_SLOTS   (HEAP_SLOTS),
    .VERTEX_COUNT (VERTEX_COUNT),
    .KEY_BITS     (KEY_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .res        (res),
    .res_ready  (res_ready),
    .heap_we    (heap_we),
    .heap_waddr (heap_waddr),
    .heap_wdata (heap_wdata),
    .heap_raddr (heap_raddr),
    .heap_rdata (heap_rdata),
    .pos_we     (pos_we),
    .pos_waddr  (pos_waddr),
    .pos_wdata  (pos_wdata),
    .pos_raddr  (pos_raddr),
    .pos_rdata  (pos_rdata)
  );

  imhq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_SLOTS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhq_ram #(
    .WIDTH (SW),
    .DEPTH (VERTEX_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  imhq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
